>>> hdl/frsp_pkg.sv
// Shared types, character codes and sequence filter for the FASTA record stream parser.
// Used by frsp_parse, frsp_out_fifo and fasta_record_stream_parser.
`timescale 1ns / 1ps

package frsp_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int REC_LEN_W       = 32;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] LOWER_LO  = 8'd96;
	localparam logic [7:0] LOWER_HI  = 8'd123;
	localparam logic [7:0] CASE_DIFF = 8'd32;

	typedef enum logic [1:0] {
		SEQ_UNTYPED = 2'd0,
		SEQ_RNA     = 2'd1,
		SEQ_DNA     = 2'd2,
		SEQ_AMINO   = 2'd3
	} seq_type_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SEQ    = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]           data;
		kind_t                kind;
		logic                 name;
		logic [REC_LEN_W-1:0] rec_len;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic    we0;
		logic    we1;
		result_t r0;
		result_t r1;
	} push_t;

	// Upper-case, then keep, remap or drop (zero means dropped).
	function automatic logic [7:0] filter_byte(input logic [7:0] c, input seq_type_t st);
		logic [7:0] u;
		logic [7:0] k;
		u = c;
		if (c > LOWER_LO && c < LOWER_HI)
			u = c - CASE_DIFF;
		k = 8'h00;
		if (u == 8'h00 || u == CH_CR || u == CH_LF) begin
			k = 8'h00;
		end else if (st == SEQ_UNTYPED) begin
			k = u;
		end else if (u == CH_DASH || u == CH_DOT) begin
			k = u;
		end else begin
			case (st)
				SEQ_RNA: begin
					if (u == CH_T)
						k = CH_U;
					else if (u inside {"A", "C", "G", "U", "R", "Y", "S", "W", "K", "M",
						"B", "D", "H", "V", "N"})
						k = u;
				end
				SEQ_DNA: begin
					if (u == CH_U)
						k = CH_T;
					else if (u inside {"A", "C", "G", "T", "R", "Y", "S", "W", "K", "M",
						"B", "D", "H", "V", "N"})
						k = u;
				end
				SEQ_AMINO: begin
					if (u inside {"A", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M",
						"N", "P", "Q", "R", "S", "T", "V", "W", "Y"})
						k = u;
				end
				default: k = u;
			endcase
		end
		return k;
	endfunction

endpackage

>>> hdl/frsp_out_fifo.sv
// Four-entry result queue: takes up to two items per cycle, gives one per cycle.
// Depends on frsp_pkg for result_t and push_t.
`timescale 1ns / 1ps

module frsp_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  frsp_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output frsp_pkg::result_t out_res
);

	localparam int PTR_W = $clog2(frsp_pkg::FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	frsp_pkg::result_t mem_q [frsp_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	logic [CNT_W-1:0]  n_push;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = CNT_W'(push.we0) + CNT_W'(push.we1);
	assign room      = (count_q <= CNT_W'(frsp_pkg::FIFO_DEPTH - 2) + CNT_W'(pop));

	always_ff @(posedge clk) begin
		if (push.we0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.we1)
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/frsp_parse.sv
// Input register, parser state and per-byte decode into up to two result items.
// Depends on frsp_pkg for the filter, character codes and result types.
`timescale 1ns / 1ps

module frsp_parse #(
	parameter int LENGTH_BITS = frsp_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_eoi,
	input  logic            room,
	output frsp_pkg::push_t push
);

	typedef enum logic [2:0] {
		PS_START, PS_HEADER, PS_SEQ, PS_COMMENT, PS_ERROR
	} mode_t;

	frsp_pkg::seq_type_t    seq_type_q;
	mode_t                  mode_q, mode_d;
	logic                   line_start_q, line_start_d;
	logic                   name_open_q, name_open_d;
	logic                   rec_open_q, rec_open_d;
	logic [LENGTH_BITS-1:0] seq_len_q, seq_len_d;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eoi_s1;
	logic                   adv;
	logic                   e_hit;
	frsp_pkg::result_t      e_res;
	logic                   x_hit;
	frsp_pkg::result_t      x_res;
	logic [7:0]             k;
	logic [63:0]            len_ext;
	logic [frsp_pkg::REC_LEN_W-1:0] len_sat;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eoi_s1  <= in_eoi;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		line_start_d = line_start_q;
		name_open_d  = name_open_q;
		rec_open_d   = rec_open_q;
		seq_len_d    = seq_len_q;
		e_hit        = 1'b0;
		e_res        = '0;
		x_hit        = 1'b0;
		x_res        = '0;
		k            = frsp_pkg::filter_byte(byte_s1, seq_type_q);
		len_ext      = 64'(seq_len_q);
		len_sat      = (len_ext > 64'hFFFF_FFFF) ? '1 : len_ext[frsp_pkg::REC_LEN_W-1:0];

		case (mode_q)
			PS_START: begin
				if (byte_s1 == frsp_pkg::CH_GT) begin
					mode_d       = PS_HEADER;
					rec_open_d   = 1'b1;
					name_open_d  = 1'b1;
					line_start_d = 1'b0;
					seq_len_d    = '0;
				end else begin
					e_hit      = 1'b1;
					e_res.kind = frsp_pkg::KIND_ERROR;
					mode_d     = PS_ERROR;
				end
			end
			PS_HEADER: begin
				if (byte_s1 == frsp_pkg::CH_LF) begin
					mode_d       = PS_SEQ;
					line_start_d = 1'b1;
				end else if (byte_s1 != frsp_pkg::CH_CR) begin
					if (byte_s1 == frsp_pkg::CH_SPACE)
						name_open_d = 1'b0;
					e_hit      = 1'b1;
					e_res.data = byte_s1;
					e_res.kind = frsp_pkg::KIND_HEADER;
					e_res.name = (byte_s1 == frsp_pkg::CH_SPACE) ? 1'b0 : name_open_q;
				end
			end
			PS_SEQ: begin
				if (line_start_q && byte_s1 == frsp_pkg::CH_GT) begin
					if (rec_open_q) begin
						e_hit         = 1'b1;
						e_res.kind    = frsp_pkg::KIND_END;
						e_res.rec_len = len_sat;
					end
					mode_d       = PS_HEADER;
					rec_open_d   = 1'b1;
					name_open_d  = 1'b1;
					line_start_d = 1'b0;
					seq_len_d    = '0;
				end else if (line_start_q && byte_s1 == frsp_pkg::CH_SEMI) begin
					mode_d       = PS_COMMENT;
					line_start_d = 1'b0;
				end else begin
					line_start_d = (byte_s1 == frsp_pkg::CH_LF);
					if (k != 8'h00) begin
						e_hit      = 1'b1;
						e_res.data = k;
						e_res.kind = frsp_pkg::KIND_SEQ;
						if (seq_len_q != '1)
							seq_len_d = seq_len_q + LENGTH_BITS'(1);
					end
				end
			end
			PS_COMMENT: begin
				if (byte_s1 == frsp_pkg::CH_LF) begin
					mode_d       = PS_SEQ;
					line_start_d = 1'b1;
				end
			end
			default: ;
		endcase

		if (eoi_s1) begin
			len_ext = 64'(seq_len_d);
			if (rec_open_d) begin
				x_hit         = 1'b1;
				x_res.kind    = frsp_pkg::KIND_END;
				x_res.rec_len = (len_ext > 64'hFFFF_FFFF) ? '1
					: len_ext[frsp_pkg::REC_LEN_W-1:0];
			end
			mode_d       = PS_START;
			line_start_d = 1'b1;
			name_open_d  = 1'b0;
			rec_open_d   = 1'b0;
			seq_len_d    = '0;
		end

		e_res.last = !x_hit;
		x_res.last = 1'b1;
		push.we0   = adv && (e_hit || x_hit);
		push.we1   = adv && e_hit && x_hit;
		push.r0    = e_hit ? e_res : x_res;
		push.r1    = x_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_type_q   <= frsp_pkg::SEQ_UNTYPED;
			valid_s1     <= 1'b0;
			mode_q       <= PS_START;
			line_start_q <= 1'b1;
			name_open_q  <= 1'b0;
			rec_open_q   <= 1'b0;
			seq_len_q    <= '0;
		end else begin
			if (cfg_we)
				seq_type_q <= frsp_pkg::seq_type_t'(cfg_data);
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv) begin
				mode_q       <= mode_d;
				line_start_q <= line_start_d;
				name_open_q  <= name_open_d;
				rec_open_q   <= rec_open_d;
				seq_len_q    <= seq_len_d;
			end
		end
	end

endmodule

>>> hdl/fasta_record_stream_parser.sv
// FASTA record stream parser, top level.
// Byte stream in on s_axis (end of file on tlast), one register write channel for the
// sequence type, result items out on m_axis.
// Depends on frsp_pkg, frsp_parse and frsp_out_fifo.
//
// Usage: feed one text byte per item; set s_axis_tlast on the final byte of a file.
// cfg_data selects the sequence type (0 untyped, 1 RNA, 2 DNA, 3 amino acid); write it
// while the block is idle, cfg_ready is always high.
// Each byte yields zero, one or two result items: header bytes (tuser kind 0, name flag
// in tuser bit 2), filtered sequence bytes (kind 1), record ends with the filtered
// length in tdata[39:8] (kind 2), or one format error (kind 3). tlast marks the final
// item caused by a byte.
// Path: a byte enters the input register on accept, is decoded and written into the
// result queue, which presents its first item on m_axis. Throughput is one byte per cycle
// while m_axis_tready is high and each byte yields at most one item; the queue drains
// one item per cycle, so two-item bytes fill it. The four-entry queue sets these rates.
// Stall: when m_axis_tready is low the queue fills; s_axis_tready drops while a byte waits
// and fewer than two entries are free after this cycle's read. No item is lost.
// Reset: arst_n clears the parser to await the first header, empties the queue and sets
// the sequence type to untyped.
`timescale 1ns / 1ps

module fasta_record_stream_parser #(
	parameter int LENGTH_BITS = frsp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] record_length
	output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] in_name
	output logic        m_axis_tlast
);

	frsp_pkg::push_t   push;
	frsp_pkg::result_t out_res;
	logic              room;

	assign cfg_ready = 1'b1;

	frsp_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eoi   (s_axis_tlast),
		.room     (room),
		.push     (push)
	);

	frsp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.rec_len, out_res.data};
	assign m_axis_tuser = {out_res.name, out_res.kind};
	assign m_axis_tlast = out_res.last;

endmodule
